/* hdl/led_matrix_scan_driver_unit_assert.svh */
// Assertion macros for the scan driver.
`ifndef LED_MATRIX_SCAN_DRIVER_UNIT_ASSERT_SVH
`define LED_MATRIX_SCAN_DRIVER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define LMSD_ASSERT_SAME(label, clk_i, rstn_i, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
    else $error("lmsd assertion failed");
`define LMSD_ASSERT_NEXT(label, clk_i, rstn_i, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
    else $error("lmsd assertion failed");
`else
`define LMSD_ASSERT_SAME(label, clk_i, rstn_i, ante, cons)
`define LMSD_ASSERT_NEXT(label, clk_i, rstn_i, ante, cons)
`endif

`endif

/* hdl/lmsd_pkg.sv */
package lmsd_pkg;

  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int POSY_W  = 6;
  localparam int LEVEL_W = 8;
  localparam int RGB_W   = 3;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_SHIFT = 1'b1
  } cmd_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  typedef logic [RGB_W-1:0] rgb_t;

endpackage

/* hdl/led_matrix_scan_driver_unit.sv */
// Channel   Handshake                 Word
// in_       in_valid / in_ready       cmd, pos_x, pos_y, red/green/blue level
// out_      out_valid / out_ready     upper_rgb, lower_rgb, row_select,
//                                     column_index, latch_row
//
// One word per cycle sustained while out_ is not stalled; a shift word reaches
// out_ via the frame store read register, then the output register. Writes give no word.
// The frame store has one write port and two registered read ports.
// After reset the store clears all PANEL_WIDTH*PANEL_HEIGHT entries
// (4608 by default) with in_ready low.
// A stalled output holds the read stage; in_ready drops when both are full or while the store clears.
module led_matrix_scan_driver_unit #(
  parameter int PANEL_WIDTH  = 96,
  parameter int PANEL_HEIGHT = 48,
  parameter int SCAN_ROWS    = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_cmd,
  input  logic [lmsd_pkg::COL_W-1:0]         in_pos_x,
  input  logic [lmsd_pkg::POSY_W-1:0]        in_pos_y,
  input  logic [lmsd_pkg::LEVEL_W-1:0]       in_red_level,
  input  logic [lmsd_pkg::LEVEL_W-1:0]       in_green_level,
  input  logic [lmsd_pkg::LEVEL_W-1:0]       in_blue_level,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [lmsd_pkg::RGB_W-1:0]         out_upper_rgb,
  output logic [lmsd_pkg::RGB_W-1:0]         out_lower_rgb,
  output logic [lmsd_pkg::ROW_W-1:0]         out_row_select,
  output logic [lmsd_pkg::COL_W-1:0]         out_column_index,
  output logic                               out_latch_row
);

`include "led_matrix_scan_driver_unit_assert.svh"

  localparam int DEPTH  = PANEL_WIDTH * PANEL_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COL_W  = lmsd_pkg::COL_W;
  localparam int ROW_W  = lmsd_pkg::ROW_W;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  logic             s1_v_r, s1_v_nxt;
  logic [ROW_W-1:0] s1_row_r;
  logic [COL_W-1:0] s1_col_r;
  logic             s1_last_r;
  logic             s1_up_ok_r;
  logic             s1_lo_ok_r;

  logic                      out_valid_r, out_valid_nxt;
  lmsd_pkg::rgb_t            out_upper_r, out_lower_r;
  logic [ROW_W-1:0]          out_row_r;
  logic [COL_W-1:0]          out_col_r;
  logic                      out_latch_r;

  logic busy;
  logic out_load;
  logic acc;
  logic acc_shift;
  logic acc_write;
  logic last;
  logic wr_in_panel;
  logic up_ok;
  logic lo_ok;
  logic [COL_W-1:0]  lo_row;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr_a;
  logic [ADDR_W-1:0] rd_addr_b;
  lmsd_pkg::rgb_t    wr_data;
  lmsd_pkg::rgb_t    rd_data_a;
  lmsd_pkg::rgb_t    rd_data_b;
  lmsd_pkg::mem_ctl_t ctl;

  assign out_load  = !out_valid_r || out_ready;
  assign in_ready  = !busy && (!s1_v_r || out_load);
  assign acc       = in_valid && in_ready;
  assign acc_shift = acc && (in_cmd == lmsd_pkg::CMD_SHIFT);
  assign acc_write = acc && (in_cmd == lmsd_pkg::CMD_WRITE);

  // write path
  assign wr_in_panel = ({1'b0, in_pos_x} < 8'(PANEL_WIDTH)) &&
                       ({1'b0, in_pos_y} < 7'(PANEL_HEIGHT));
  assign wr_addr = wr_in_panel ?
                   ADDR_W'(ADDR_W'(in_pos_y) * ADDR_W'(PANEL_WIDTH) + ADDR_W'(in_pos_x)) :
                   '0;
  assign wr_data = {in_blue_level[7], in_green_level[7], in_red_level[7]};

  // scan read path
  assign last   = (col_r == COL_W'(PANEL_WIDTH - 1));
  assign lo_row = COL_W'(row_r) + COL_W'(SCAN_ROWS);
  assign up_ok  = (COL_W'(row_r) < COL_W'(PANEL_HEIGHT));
  assign lo_ok  = (lo_row < COL_W'(PANEL_HEIGHT));
  assign rd_addr_a = up_ok ?
                     ADDR_W'(ADDR_W'(row_r) * ADDR_W'(PANEL_WIDTH) + ADDR_W'(col_r)) : '0;
  assign rd_addr_b = lo_ok ?
                     ADDR_W'(ADDR_W'(lo_row) * ADDR_W'(PANEL_WIDTH) + ADDR_W'(col_r)) : '0;

  assign ctl.wr_en = acc_write && wr_in_panel;
  assign ctl.rd_en = acc_shift;

  lmsd_frame_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .busy      (busy)
  );

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (acc_shift) begin
      if (last) begin
        col_nxt = '0;
        row_nxt = (row_r == ROW_W'(SCAN_ROWS - 1)) ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (acc_shift) begin
      s1_v_nxt = 1'b1;
    end else if (out_load) begin
      s1_v_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      s1_v_r      <= s1_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_shift) begin
      s1_row_r   <= row_r;
      s1_col_r   <= col_r;
      s1_last_r  <= last;
      s1_up_ok_r <= up_ok;
      s1_lo_ok_r <= lo_ok;
    end
    if (out_load && s1_v_r) begin
      out_upper_r <= s1_up_ok_r ? rd_data_a : lmsd_pkg::rgb_t'(0);
      out_lower_r <= s1_lo_ok_r ? rd_data_b : lmsd_pkg::rgb_t'(0);
      out_row_r   <= s1_row_r;
      out_col_r   <= s1_col_r;
      out_latch_r <= s1_last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_upper_rgb    = out_upper_r;
  assign out_lower_rgb    = out_lower_r;
  assign out_row_select   = out_row_r;
  assign out_column_index = out_col_r;
  assign out_latch_row    = out_latch_r;

  `LMSD_ASSERT_SAME(a_no_accept_in_clear, clk, rst_n, busy, !in_ready)
  `LMSD_ASSERT_NEXT(a_shift_enters_read, clk, rst_n, acc_shift, s1_v_r)
  `LMSD_ASSERT_SAME(a_row_in_range, clk, rst_n, 1'b1, ({1'b0, row_r} < 6'(SCAN_ROWS)))
  `LMSD_ASSERT_SAME(a_latch_on_last, clk, rst_n, out_valid_r,
                    out_latch_r == (out_col_r == COL_W'(PANEL_WIDTH - 1)))
  `LMSD_ASSERT_NEXT(a_stall_holds_read, clk, rst_n, s1_v_r && !out_load, s1_v_r)

endmodule

/* hdl/lmsd_frame_store.sv */
module lmsd_frame_store #(
  parameter int DEPTH  = 4608,
  parameter int ADDR_W = 13
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lmsd_pkg::mem_ctl_t  ctl,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  lmsd_pkg::rgb_t      wr_data,
  input  logic [ADDR_W-1:0]   rd_addr_a,
  input  logic [ADDR_W-1:0]   rd_addr_b,
  output lmsd_pkg::rgb_t      rd_data_a,
  output lmsd_pkg::rgb_t      rd_data_b,
  output logic                busy
);

  lmsd_pkg::rgb_t mem [DEPTH];

  logic              clr_busy_r;
  logic              clr_busy_nxt;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [ADDR_W-1:0] clr_addr_nxt;
  lmsd_pkg::rgb_t    rd_a_r;
  lmsd_pkg::rgb_t    rd_b_r;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  lmsd_pkg::rgb_t    wdata;

  // clear sweep after reset, one entry per cycle
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end else begin
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  assign we    = clr_busy_r | ctl.wr_en;
  assign waddr = clr_busy_r ? clr_addr_r : wr_addr;
  assign wdata = clr_busy_r ? lmsd_pkg::rgb_t'(0) : wr_data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;
  assign busy      = clr_busy_r;

endmodule

/* tb/led_matrix_scan_driver_unit_tb.sv */
`timescale 1ns / 1ps

module led_matrix_scan_driver_unit_tb;

  localparam int PANEL_W    = 96;
  localparam int PANEL_H    = 48;
  localparam int SCAN_ROWS  = 24;
  localparam int N_DIRECTED = 24;
  localparam int N_RANDOM   = 1550;
  localparam int COL_W      = lmsd_pkg::COL_W;
  localparam int ROW_W      = lmsd_pkg::ROW_W;
  localparam int POSY_W     = lmsd_pkg::POSY_W;
  localparam int LEVEL_W    = lmsd_pkg::LEVEL_W;

  typedef struct packed {
    lmsd_pkg::cmd_t      cmd;
    logic [COL_W-1:0]    pos_x;
    logic [POSY_W-1:0]   pos_y;
    logic [LEVEL_W-1:0]  red;
    logic [LEVEL_W-1:0]  green;
    logic [LEVEL_W-1:0]  blue;
  } panel_word_t;

  typedef struct packed {
    lmsd_pkg::rgb_t    upper;
    lmsd_pkg::rgb_t    lower;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              latch;
  } column_t;

  typedef struct packed {
    lmsd_pkg::cmd_t      cmd;
    logic [COL_W-1:0]    pos_x;
    logic [POSY_W-1:0]   pos_y;
    logic [LEVEL_W-1:0]  red;
    logic [LEVEL_W-1:0]  green;
    logic [LEVEL_W-1:0]  blue;
    logic                typed;
    lmsd_pkg::rgb_t      upper;
    lmsd_pkg::rgb_t      lower;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic                latch;
  } stim_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic                in_cmd;
  logic [COL_W-1:0]    in_pos_x;
  logic [POSY_W-1:0]   in_pos_y;
  logic [LEVEL_W-1:0]  in_red_level;
  logic [LEVEL_W-1:0]  in_green_level;
  logic [LEVEL_W-1:0]  in_blue_level;
  logic                out_valid;
  logic                out_ready = 1'b0;
  lmsd_pkg::rgb_t      out_upper_rgb;
  lmsd_pkg::rgb_t      out_lower_rgb;
  logic [ROW_W-1:0]    out_row_select;
  logic [COL_W-1:0]    out_column_index;
  logic                out_latch_row;

  led_matrix_scan_driver_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_red_level     (in_red_level),
    .in_green_level   (in_green_level),
    .in_blue_level    (in_blue_level),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_upper_rgb    (out_upper_rgb),
    .out_lower_rgb    (out_lower_rgb),
    .out_row_select   (out_row_select),
    .out_column_index (out_column_index),
    .out_latch_row    (out_latch_row)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // panel image and scan position as the block should hold them
  logic [23:0]       pixel_mem [PANEL_W*PANEL_H];
  logic [ROW_W-1:0]  scan_row_q;
  logic [COL_W-1:0]  scan_col_q;
  column_t           pending_columns [$];
  stim_row_t         stim_tab [N_DIRECTED];
  bit                steady;
  int                n_writes;
  int                n_off_panel;
  int                n_columns;
  int                n_latches;
  int                errors;

  function automatic lmsd_pkg::rgb_t pixel_msbs(int x, int y);
    logic [23:0] p;
    if (x >= PANEL_W || y >= PANEL_H) return '0;
    p = pixel_mem[y*PANEL_W + x];
    return {p[23], p[15], p[7]};
  endfunction

  task automatic scan_step(input panel_word_t w, output bit shifted, output column_t c);
    shifted = 1'b0;
    c = '0;
    if (w.cmd == lmsd_pkg::CMD_WRITE) begin
      n_writes++;
      if (w.pos_x < PANEL_W && w.pos_y < PANEL_H) begin
        pixel_mem[int'(w.pos_y)*PANEL_W + int'(w.pos_x)] = {w.blue, w.green, w.red};
      end else begin
        n_off_panel++;
      end
    end else begin
      shifted = 1'b1;
      c.upper = pixel_msbs(int'(scan_col_q), int'(scan_row_q));
      c.lower = pixel_msbs(int'(scan_col_q), int'(scan_row_q) + SCAN_ROWS);
      c.row   = scan_row_q;
      c.col   = scan_col_q;
      c.latch = (scan_col_q >= PANEL_W - 1);
      n_columns++;
      if (c.latch) begin
        n_latches++;
        scan_col_q = '0;
        scan_row_q = ROW_W'((int'(scan_row_q) + 1) % SCAN_ROWS);
      end else begin
        scan_col_q = scan_col_q + COL_W'(1);
      end
    end
  endtask

  // mostly shifts and writes aimed at the pixels about to be scanned
  function automatic panel_word_t random_word();
    panel_word_t w;
    int pick;
    w.cmd   = lmsd_pkg::CMD_WRITE;
    w.pos_x = COL_W'($urandom_range(127));
    w.pos_y = POSY_W'($urandom_range(63));
    w.red   = LEVEL_W'($urandom_range(255));
    w.green = LEVEL_W'($urandom_range(255));
    w.blue  = LEVEL_W'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 58) begin
      w.cmd = lmsd_pkg::CMD_SHIFT;
    end else if (pick < 86) begin
      w.pos_x = COL_W'(int'(scan_col_q) + int'($urandom_range(3)));
      w.pos_y = POSY_W'(int'(scan_row_q) + (($urandom_range(1) != 0) ? SCAN_ROWS : 0));
    end else if (pick < 95) begin
      w.pos_x = COL_W'($urandom_range(PANEL_W - 1));
      w.pos_y = POSY_W'($urandom_range(PANEL_H - 1));
    end
    return w;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input panel_word_t w, input logic typed, input column_t exp);
    bit shifted;
    column_t c;
    while (!steady && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_cmd         <= w.cmd;
    in_pos_x       <= w.pos_x;
    in_pos_y       <= w.pos_y;
    in_red_level   <= w.red;
    in_green_level <= w.green;
    in_blue_level  <= w.blue;
    do @(posedge clk); while (in_ready !== 1'b1);
    scan_step(w, shifted, c);
    if (shifted) pending_columns.push_back(typed ? exp : c);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_columns.size() != 0);
  endtask

  task automatic check_field(input string name, input int exp, input int got);
    if (exp != got) begin
      $error("%s: expected %0d, got %0d", name, exp, got);
      errors++;
    end
  endtask

  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 24);
  end

  always @(posedge clk) begin : column_check
    column_t e;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_columns.size() == 0) begin
        $error("column word with none expected");
        errors++;
      end else begin
        e = pending_columns.pop_front();
        if ($isunknown({out_upper_rgb, out_lower_rgb, out_row_select, out_column_index,
                        out_latch_row})) begin
          $error("column word carries unknown bits");
          errors++;
        end
        check_field("upper_rgb", int'(e.upper), int'(out_upper_rgb));
        check_field("lower_rgb", int'(e.lower), int'(out_lower_rgb));
        check_field("row_select", int'(e.row), int'(out_row_select));
        check_field("column_index", int'(e.col), int'(out_column_index));
        check_field("latch_row", int'(e.latch), int'(out_latch_row));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    panel_word_t w;
    column_t exp;
    in_valid       = 1'b0;
    in_cmd         = 1'b0;
    in_pos_x       = '0;
    in_pos_y       = '0;
    in_red_level   = '0;
    in_green_level = '0;
    in_blue_level  = '0;
    rst_n          = 1'b0;
    steady         = 1'b0;
    scan_row_q     = '0;
    scan_col_q     = '0;
    foreach (pixel_mem[i]) pixel_mem[i] = '0;

    //            cmd                  x    y    red    green  blue  typ up lo row col lat
    stim_tab = '{
      '{lmsd_pkg::CMD_SHIFT,   0,   0, 8'h00, 8'h00, 8'h00, 1, 0, 0, 0, 0, 0},
      '{lmsd_pkg::CMD_WRITE,   1,   0, 8'hff, 8'h00, 8'h00, 0, 0, 0, 0, 0, 0},
      '{lmsd_pkg::CMD_WRITE,   1,  24, 8'h00, 8'h80, 8'h00, 0, 0, 0, 0, 0, 0},
      '{lmsd_pkg::CMD_WRITE,  96,   0, 8'hff, 8'hff, 8'hff, 0, 0, 0, 0, 0, 0},
      '{lmsd_pkg::CMD_WRITE, 127,  63, 8'hff, 8'hff, 8'hff, 0, 0, 0, 0, 0, 0},
      '{lmsd_pkg::CMD_WRITE,   2,  48, 8'hff, 8'hff, 8'hff, 0, 0, 0, 0, 0, 0},
      '{lmsd_pkg::CMD_SHIFT,   0,   0, 8'h00, 8'h00, 8'h00, 1, 1, 2, 0, 1, 0},
      '{lmsd_pkg::CMD_WRITE,   2,   0, 8'h7f, 8'h7f, 8'h7f, 0, 0, 0, 0, 0, 0},
      '{lmsd_pkg::CMD_WRITE,   2,  24, 8'h80, 8'h80, 8'h80, 0, 0, 0, 0, 0, 0},
      '{lmsd_pkg::CMD_SHIFT, 127,  63, 8'hff, 8'hff, 8'hff, 1, 0, 7, 0, 2, 0},
      '{lmsd_pkg::CMD_WRITE,   3,   0, 8'h00, 8'h00, 8'h80, 0, 0, 0, 0, 0, 0},
      '{lmsd_pkg::CMD_WRITE,   3,  24, 8'hff, 8'hff, 8'hff, 0, 0, 0, 0, 0, 0},
      '{lmsd_pkg::CMD_WRITE,   3,  24, 8'h00, 8'h00, 8'h00, 0, 0, 0, 0, 0, 0},
      '{lmsd_pkg::CMD_SHIFT,   0,   0, 8'h00, 8'h00, 8'h00, 1, 4, 0, 0, 3, 0},
      '{lmsd_pkg::CMD_WRITE,  95,  47, 8'hff, 8'hff, 8'hff, 0, 0, 0, 0, 0, 0},
      '{lmsd_pkg::CMD_WRITE,   0,   0, 8'hff, 8'hff, 8'hff, 0, 0, 0, 0, 0, 0},
      '{lmsd_pkg::CMD_WRITE,   4,   0, 8'hc0, 8'h40, 8'h80, 0, 0, 0, 0, 0, 0},
      '{lmsd_pkg::CMD_WRITE,   4,  24, 8'h40, 8'hc0, 8'h7f, 0, 0, 0, 0, 0, 0},
      '{lmsd_pkg::CMD_SHIFT,   0,   0, 8'h00, 8'h00, 8'h00, 0, 0, 0, 0, 0, 0},
      '{lmsd_pkg::CMD_WRITE,   5,  63, 8'hff, 8'hff, 8'hff, 0, 0, 0, 0, 0, 0},
      '{lmsd_pkg::CMD_WRITE,  64,  32, 8'h55, 8'haa, 8'hcc, 0, 0, 0, 0, 0, 0},
      '{lmsd_pkg::CMD_SHIFT,   0,   0, 8'h00, 8'h00, 8'h00, 1, 0, 0, 0, 5, 0},
      '{lmsd_pkg::CMD_WRITE,   6,   0, 8'hff, 8'h80, 8'h00, 0, 0, 0, 0, 0, 0},
      '{lmsd_pkg::CMD_SHIFT,   0,   0, 8'h00, 8'h00, 8'h00, 1, 3, 0, 0, 6, 0}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // in_ready stays low through the store clear; the handshake waits it out
    foreach (stim_tab[i]) begin
      w   = '{stim_tab[i].cmd, stim_tab[i].pos_x, stim_tab[i].pos_y,
              stim_tab[i].red, stim_tab[i].green, stim_tab[i].blue};
      exp = '{stim_tab[i].upper, stim_tab[i].lower, stim_tab[i].row,
              stim_tab[i].col, stim_tab[i].latch};
      send_word(w, stim_tab[i].typed, exp);
    end
    drain();

    for (int i = 0; i < N_RANDOM; i++) begin
      steady = (i >= 800 && i < 1100);
      if (i == 400) drain();
      send_word(random_word(), 1'b0, '0);
    end
    drain();
    repeat (8) @(posedge clk);

    $display("Sent %0d pixel writes (%0d off panel) and %0d column shifts,",
             n_writes, n_off_panel, n_columns);
    $display("crossing %0d row latches; scan ended on row %0d column %0d.",
             n_latches, scan_row_q, scan_col_q);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/lmsd_pkg.sv
hdl/lmsd_frame_store.sv
hdl/led_matrix_scan_driver_unit.sv
tb/led_matrix_scan_driver_unit_tb.sv
